// ----- rtl/dpb_pkg.sv -----
package dpb_pkg;

  localparam int COORD_BITS_DEF = 11;
  localparam int COORD_W        = 11;
  localparam int DEPTH_W        = 16;
  localparam int COLOR_W        = 8;
  localparam int RECIP_W        = 24;
  localparam int CENTER_W       = 15;
  localparam int OUT_W          = 26;
  localparam int ZPROD_W        = DEPTH_W + RECIP_W;
  localparam int NSTAGES        = 7;
  localparam int CFG_IDX_W      = 3;
  localparam int CFG_DATA_W     = 24;

  localparam logic [CFG_IDX_W-1:0] REG_INV_DEPTH_SCALE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_X        = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y        = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INV_FOCAL_X     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_INV_FOCAL_Y     = 3'd4;

  localparam logic [RECIP_W-1:0]  RST_INV_DEPTH_SCALE = 24'd16777;
  localparam logic [CENTER_W-1:0] RST_CENTER_X        = 15'd5208;
  localparam logic [CENTER_W-1:0] RST_CENTER_Y        = 15'd4056;
  localparam logic [RECIP_W-1:0]  RST_INV_FOCAL_X     = 24'd32263;
  localparam logic [RECIP_W-1:0]  RST_INV_FOCAL_Y     = 24'd32263;

  typedef struct packed {
    logic [RECIP_W-1:0]  inv_depth_scale;
    logic [CENTER_W-1:0] center_x;
    logic [CENTER_W-1:0] center_y;
    logic [RECIP_W-1:0]  inv_focal_x;
    logic [RECIP_W-1:0]  inv_focal_y;
  } cfg_t;

  typedef struct packed {
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
  } color_t;

endpackage

// ----- rtl/dpb_cfg_regs.sv -----
module dpb_cfg_regs
  import dpb_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  wr_en,
  input  logic [CFG_IDX_W-1:0]  wr_index,
  input  logic [CFG_DATA_W-1:0] wr_data,
  output cfg_t                  cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.inv_depth_scale <= RST_INV_DEPTH_SCALE;
      cfg.center_x        <= RST_CENTER_X;
      cfg.center_y        <= RST_CENTER_Y;
      cfg.inv_focal_x     <= RST_INV_FOCAL_X;
      cfg.inv_focal_y     <= RST_INV_FOCAL_Y;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_INV_DEPTH_SCALE: cfg.inv_depth_scale <= wr_data[RECIP_W-1:0];
        REG_CENTER_X:        cfg.center_x        <= wr_data[CENTER_W-1:0];
        REG_CENTER_Y:        cfg.center_y        <= wr_data[CENTER_W-1:0];
        REG_INV_FOCAL_X:     cfg.inv_focal_x     <= wr_data[RECIP_W-1:0];
        REG_INV_FOCAL_Y:     cfg.inv_focal_y     <= wr_data[RECIP_W-1:0];
        default: begin
        end
      endcase
    end
  end

endmodule

// ----- rtl/dpb_depth_scale.sv -----
module dpb_depth_scale
  import dpb_pkg::*;
(
  input  logic                 clk,
  input  logic [NSTAGES-1:0]   en,
  input  logic [DEPTH_W-1:0]   raw_depth,
  input  logic [RECIP_W-1:0]   inv_depth_scale,
  output logic [OUT_W-1:0]     z_early,
  output logic [OUT_W-1:0]     z_late
);

  logic [ZPROD_W-1:0] zprod;
  logic [OUT_W-1:0]   z_pipe [1:NSTAGES-1];
  logic [OUT_W-1:0]   z_sat;

  always_comb begin
    if (zprod[ZPROD_W-1:OUT_W+8] != '0) begin
      z_sat = '1;
    end else begin
      z_sat = zprod[OUT_W+7:8];
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      zprod <= ZPROD_W'(raw_depth) * ZPROD_W'(inv_depth_scale);
    end
    if (en[1]) begin
      z_pipe[1] <= z_sat;
    end
    for (int k = 2; k < NSTAGES; k++) begin
      if (en[k]) begin
        z_pipe[k] <= z_pipe[k-1];
      end
    end
  end

  assign z_early = z_pipe[1];
  assign z_late  = z_pipe[NSTAGES-1];

endmodule

// ----- rtl/dpb_lateral.sv -----
module dpb_lateral
  import dpb_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                    clk,
  input  logic [NSTAGES-1:0]      en,
  input  logic [COORD_W-1:0]      pos,
  input  logic [CENTER_W-1:0]     center,
  input  logic [RECIP_W-1:0]      recip,
  input  logic [OUT_W-1:0]        z,
  output logic signed [OUT_W-1:0] coord
);

  localparam int DW   = (COORD_BITS + 4 > CENTER_W) ? COORD_BITS + 4 : CENTER_W;
  localparam int PW   = DW + OUT_W;
  localparam int TW   = PW - 4;
  localparam int LW   = 20;
  localparam int HW   = TW - LW;
  localparam int FW   = TW + RECIP_W;
  localparam int QW   = TW + 1;
  localparam logic [QW-1:0] NEG_LIM = QW'(1) << (OUT_W - 1);
  localparam logic [QW-1:0] POS_LIM = NEG_LIM - QW'(1);

  logic [COORD_BITS-1:0]    pos_c;
  logic [DW-1:0]            p4;
  logic [DW-1:0]            cext;
  logic                     neg_pipe [0:NSTAGES-2];
  logic [DW-1:0]            dmag0;
  logic [DW-1:0]            dmag1;
  logic [PW-1:0]            prod2;
  logic [TW-1:0]            tmag3;
  logic [LW+RECIP_W-1:0]    pl4;
  logic [HW+RECIP_W-1:0]    ph4;
  logic [FW-1:0]            full;
  logic [TW-1:0]            qbase5;
  logic                     sticky5;
  logic [QW-1:0]            qmag;
  logic [OUT_W-1:0]         coord_next;

  assign pos_c = COORD_BITS'(pos);
  assign p4    = DW'({pos_c, 4'b0000});
  assign cext  = DW'(center);
  assign full  = {ph4, {LW{1'b0}}} + FW'(pl4);
  assign qmag  = QW'(qbase5) + QW'(neg_pipe[NSTAGES-2] && sticky5);

  always_comb begin
    if (neg_pipe[NSTAGES-2]) begin
      if (qmag > NEG_LIM) begin
        coord_next = OUT_W'(NEG_LIM);
      end else begin
        coord_next = OUT_W'(~qmag + QW'(1));
      end
    end else if (qmag > POS_LIM) begin
      coord_next = OUT_W'(POS_LIM);
    end else begin
      coord_next = OUT_W'(qmag);
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      neg_pipe[0] <= p4 < cext;
      dmag0       <= (p4 < cext) ? cext - p4 : p4 - cext;
    end
    for (int k = 1; k < NSTAGES - 1; k++) begin
      if (en[k]) begin
        neg_pipe[k] <= neg_pipe[k-1];
      end
    end
    if (en[1]) begin
      dmag1 <= dmag0;
    end
    if (en[2]) begin
      prod2 <= PW'(dmag1) * PW'(z);
    end
    if (en[3]) begin
      tmag3 <= prod2[PW-1:4] + TW'(neg_pipe[2] && (prod2[3:0] != 4'b0000));
    end
    if (en[4]) begin
      pl4 <= (LW+RECIP_W)'(tmag3[LW-1:0]) * (LW+RECIP_W)'(recip);
      ph4 <= (HW+RECIP_W)'(tmag3[TW-1:LW]) * (HW+RECIP_W)'(recip);
    end
    if (en[5]) begin
      qbase5  <= full[FW-1:RECIP_W];
      sticky5 <= full[RECIP_W-1:0] != '0;
    end
    if (en[6]) begin
      coord <= coord_next;
    end
  end

endmodule

// ----- rtl/depth_pixel_backprojection.sv -----
// Back-projects a stream of depth pixels into 3D points with a pinhole camera model: z is the
// raw depth times a Q0.24 depth reciprocal, and x and y are the pixel offset from the principal
// point times z times the Q0.24 focal reciprocals, all truncated toward minus infinity and
// saturated to 26 bits in Q10.16 metres, with the color carried alongside. A pixel whose raw
// depth is zero produces no output word. The datapath is a seven-stage pipeline whose longest
// step is one multiplier, so it takes one pixel per clock while the output is not stalled,
// and each point passes through every stage register in order to the output. An output stall
// reaches the input stall in the same cycle once every stage holds a word, and empty stages
// are filled while the output is stalled. Registers are written through the configuration
// port, which is always ready, and should only be changed while no pixels are in flight.
module depth_pixel_backprojection
  import dpb_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_data,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [COORD_W-1:0]      column,
  input  logic [COORD_W-1:0]      row,
  input  logic [DEPTH_W-1:0]      raw_depth,
  input  logic [COLOR_W-1:0]      red_in,
  input  logic [COLOR_W-1:0]      green_in,
  input  logic [COLOR_W-1:0]      blue_in,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic signed [OUT_W-1:0] point_x,
  output logic signed [OUT_W-1:0] point_y,
  output logic [OUT_W-1:0]        point_z,
  output logic [COLOR_W-1:0]      red_out,
  output logic [COLOR_W-1:0]      green_out,
  output logic [COLOR_W-1:0]      blue_out
);

  cfg_t                 cfg;
  logic [NSTAGES-1:0]   en;
  logic [NSTAGES-1:0]   valid;
  color_t               color_pipe [0:NSTAGES-1];
  logic [OUT_W-1:0]     z_early;

  assign cfg_ready = 1'b1;

  dpb_cfg_regs u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  always_comb begin
    en[NSTAGES-1] = !valid[NSTAGES-1] || !out_stall;
    for (int k = NSTAGES - 2; k >= 0; k--) begin
      en[k] = !valid[k] || en[k+1];
    end
  end

  assign in_stall = !en[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      if (en[0]) begin
        valid[0] <= in_valid && (raw_depth != '0);
      end
      for (int k = 1; k < NSTAGES; k++) begin
        if (en[k]) begin
          valid[k] <= valid[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      color_pipe[0] <= '{red: red_in, green: green_in, blue: blue_in};
    end
    for (int k = 1; k < NSTAGES; k++) begin
      if (en[k]) begin
        color_pipe[k] <= color_pipe[k-1];
      end
    end
  end

  dpb_depth_scale u_depth (
    .clk             (clk),
    .en              (en),
    .raw_depth       (raw_depth),
    .inv_depth_scale (cfg.inv_depth_scale),
    .z_early         (z_early),
    .z_late          (point_z)
  );

  dpb_lateral #(
    .COORD_BITS (COORD_BITS)
  ) u_lat_x (
    .clk    (clk),
    .en     (en),
    .pos    (column),
    .center (cfg.center_x),
    .recip  (cfg.inv_focal_x),
    .z      (z_early),
    .coord  (point_x)
  );

  dpb_lateral #(
    .COORD_BITS (COORD_BITS)
  ) u_lat_y (
    .clk    (clk),
    .en     (en),
    .pos    (row),
    .center (cfg.center_y),
    .recip  (cfg.inv_focal_y),
    .z      (z_early),
    .coord  (point_y)
  );

  assign out_valid = valid[NSTAGES-1];
  assign red_out   = color_pipe[NSTAGES-1].red;
  assign green_out = color_pipe[NSTAGES-1].green;
  assign blue_out  = color_pipe[NSTAGES-1].blue;

endmodule
